>>> rtl/decimal_seven_segment_shift_out_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal seven-segment shift-out block
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_SEVEN_SEGMENT_SHIFT_OUT_TOP_DEFINES_SVH
`define DECIMAL_SEVEN_SEGMENT_SHIFT_OUT_TOP_DEFINES_SVH

// ante holds, cons holds in the same cycle
`define DSSO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsso: same-cycle check failed");

// ante holds, cons holds in the next cycle
`define DSSO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsso: next-cycle check failed");

`endif

>>> rtl/dsso_pkg.sv
// ----------------------------------------------------------------------------
// dsso_pkg
// Constants and segment table for the decimal seven-segment shift-out block.
// ----------------------------------------------------------------------------
package dsso_pkg;

    localparam int VALUE_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int POS_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    // value / 10 == (value * RECIP) >> RECIP_SHIFT for all 16-bit values
    localparam logic [VALUE_W-1:0] RECIP       = 16'd52429;
    localparam int                 RECIP_SHIFT = 19;

    localparam logic [BYTE_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [BYTE_W-1:0] SEG_ZERO  = 8'h6F;

    function automatic logic [BYTE_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [BYTE_W-1:0] pat;
        case (digit)
            4'd0:    pat = SEG_ZERO;
            4'd1:    pat = 8'h0A;
            4'd2:    pat = 8'h76;
            4'd3:    pat = 8'h5E;
            4'd4:    pat = 8'h1B;
            4'd5:    pat = 8'h5D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h0E;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h5F;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

>>> rtl/decimal_seven_segment_shift_out_top.sv
// Output rate: the serialiser sends one frame bit per clock; a queued frame follows
//   with no gap, and the converter can take the next value while a frame is sent.
// Reset: synchronous, active low; clears converter state, queue and serialiser.
// Output bits are strobed for one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
// decimal_seven_segment_shift_out_top
// Binary to decimal, segment encoding and serial shift-out for a display chain.
// ----------------------------------------------------------------------------
module decimal_seven_segment_shift_out_top #(
    parameter int DIGIT_COUNT = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [dsso_pkg::VALUE_W-1:0]  i_value,
    output logic                          busy,
    output logic                          o_strobe,
    output logic                          o_serial_bit,
    output logic [dsso_pkg::POS_W-1:0]    o_bit_position,
    output logic                          o_latch_after
);

    localparam int FRAME_BITS = dsso_pkg::BYTE_W * (1 + DIGIT_COUNT);

    logic                  w_push;
    logic                  w_full;
    logic                  w_pop;
    logic                  w_empty;
    logic [FRAME_BITS-1:0] w_front_frame;
    logic [FRAME_BITS-1:0] w_queue_frame;

    dsso_front #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .FRAME_BITS  (FRAME_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_value (i_value),
        .busy    (busy),
        .o_push  (w_push),
        .o_frame (w_front_frame),
        .i_full  (w_full)
    );

    dsso_queue #(
        .FRAME_BITS (FRAME_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_front_frame),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_frame (w_queue_frame)
    );

    dsso_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_frame        (w_queue_frame),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_serial_bit   (o_serial_bit),
        .o_bit_position (o_bit_position),
        .o_latch_after  (o_latch_after)
    );

endmodule

>>> rtl/dsso_front.sv
// ----------------------------------------------------------------------------
// dsso_front
// Takes a value, peels off one decimal digit a cycle and builds the frame.
// ----------------------------------------------------------------------------
module dsso_front #(
    parameter int DIGIT_COUNT = 5,
    parameter int FRAME_BITS  = 8 * (1 + DIGIT_COUNT)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic [dsso_pkg::VALUE_W-1:0]    i_value,
    output logic                            busy,
    output logic                            o_push,
    output logic [FRAME_BITS-1:0]           o_frame,
    input  logic                            i_full
);

    localparam int          K_W    = $clog2(DIGIT_COUNT);
    localparam logic [K_W-1:0] LAST_K = K_W'(DIGIT_COUNT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                      r_state, n_state;
    logic [K_W-1:0]                  r_k, n_k;
    logic [dsso_pkg::VALUE_W-1:0]    r_v, n_v;
    logic [FRAME_BITS-1:0]           r_frame, n_frame;

    logic [2*dsso_pkg::VALUE_W-1:0]  w_prod;
    logic [dsso_pkg::VALUE_W-1:0]    w_quot;
    logic [dsso_pkg::VALUE_W-1:0]    w_tens;
    logic [dsso_pkg::DIGIT_W-1:0]    w_rem;
    logic [dsso_pkg::BYTE_W-1:0]     w_seg;

    always_comb begin
        w_prod = 32'(r_v) * 32'(dsso_pkg::RECIP);
        w_quot = 16'(w_prod >> dsso_pkg::RECIP_SHIFT);
        w_tens = {w_quot[12:0], 3'b000} + {w_quot[14:0], 1'b0};
        w_rem  = 4'(r_v - w_tens);
        w_seg  = ((r_k == '0) || (r_v != '0)) ? dsso_pkg::seg_pattern(w_rem)
                                              : dsso_pkg::SEG_BLANK;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_push  = (r_state == ST_HOLD) && !i_full;
    assign o_frame = r_frame;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_v     = r_v;
        n_frame = r_frame;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CONV;
                    n_k     = '0;
                    n_v     = i_value;
                    n_frame = {dsso_pkg::SEG_ZERO, {(FRAME_BITS - dsso_pkg::BYTE_W){1'b0}}};
                end
            end
            ST_CONV: begin
                n_v     = w_quot;
                n_frame = {w_seg, r_frame[FRAME_BITS-1:dsso_pkg::BYTE_W]};
                n_k     = r_k + 1'b1;
                if (r_k == LAST_K) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!i_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_k     <= n_k;
        r_v     <= n_v;
        r_frame <= n_frame;
    end

endmodule

>>> rtl/dsso_queue.sv
// ----------------------------------------------------------------------------
// dsso_queue
// Two-entry frame queue between the converter and the serialiser.
// ----------------------------------------------------------------------------
`include "decimal_seven_segment_shift_out_top_defines.svh"

module dsso_queue #(
    parameter int FRAME_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [FRAME_BITS-1:0] i_frame,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [FRAME_BITS-1:0] o_frame
);

    localparam int DEPTH = dsso_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [FRAME_BITS-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]      r_wr, n_wr;
    logic [PTR_W-1:0]      r_rd, n_rd;
    logic [CNT_W-1:0]      r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_frame = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    `DSSO_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `DSSO_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

>>> rtl/dsso_back.sv
// ----------------------------------------------------------------------------
// dsso_back
// Serialiser: shifts each frame out one bit a cycle, LSB first.
// ----------------------------------------------------------------------------
`include "decimal_seven_segment_shift_out_top_defines.svh"

module dsso_back #(
    parameter int FRAME_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  logic [FRAME_BITS-1:0]         i_frame,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic                          o_serial_bit,
    output logic [dsso_pkg::POS_W-1:0]    o_bit_position,
    output logic                          o_latch_after
);

    localparam int CNT_W = $clog2(FRAME_BITS);
    localparam logic [CNT_W-1:0]           LAST_POS   = CNT_W'(FRAME_BITS - 1);
    localparam logic [dsso_pkg::POS_W-1:0] LAST_POS_O = dsso_pkg::POS_W'(FRAME_BITS - 1);

    logic                  r_active, n_active;
    logic [CNT_W-1:0]      r_pos, n_pos;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic                  w_last;

    assign w_last = r_active && (r_pos == LAST_POS);
    assign o_pop  = (!r_active || w_last) && !i_empty;

    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        n_shift  = r_shift;
        if (r_active && !w_last) begin
            n_pos   = r_pos + 1'b1;
            n_shift = {1'b0, r_shift[FRAME_BITS-1:1]};
        end else if (o_pop) begin
            n_active = 1'b1;
            n_pos    = '0;
            n_shift  = i_frame;
        end else begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else begin
            r_active <= n_active;
            r_pos    <= n_pos;
        end
        r_shift <= n_shift;
    end

    assign o_strobe       = r_active;
    assign o_serial_bit   = r_shift[0];
    assign o_bit_position = dsso_pkg::POS_W'(r_pos);
    assign o_latch_after  = w_last;

    `DSSO_ASSERT_NOW(a_latch_on_last, i_clk, i_rst_n, o_latch_after, o_bit_position == LAST_POS_O)
    `DSSO_ASSERT_NEXT(a_frame_contiguous, i_clk, i_rst_n, o_strobe && !o_latch_after, o_strobe && (o_bit_position == $past(o_bit_position) + 6'd1))

endmodule
